// ----- rtl/core/ltsd_pkg.sv -----
// shared types and constants of the lz77 token stream decoder
package ltsd_pkg;

    // history ring and per-stream byte counter
    localparam int HISTORY_BYTES = 4096;
    localparam int HIST_AW       = $clog2(HISTORY_BYTES);
    localparam int PROD_W        = HIST_AW + 1;

    // output chunking
    localparam int CHUNK_BYTES = 8;
    localparam int IDX_W       = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
    localparam int CNT_W       = 4;
    localparam int DATA_W      = 64;

    // token format
    localparam int       FLAG_BIT       = 7;
    localparam logic [7:0] OFFSET_HI_MASK = 8'h0F;
    localparam int       OFF_W          = 12;
    localparam int       LEN_W          = 9;
    localparam logic [LEN_W-1:0] MIN_MATCH = LEN_W'(3);

    // command queue between parser and copy engine
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_TRUNC      = 2'd1,
        ST_BAD_OFFSET = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_LIT   = 2'd1,
        CMD_MATCH = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        logic [7:0] token_byte;
        logic       stream_end;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] chunk_data;
        logic [CNT_W-1:0]  chunk_count;
        logic              last_of_stream;
        logic [1:0]        decode_status;
    } t_out_chunk;

    // literal byte or match length minus three, plus stream end information
    typedef struct packed {
        t_cmd_kind        kind;
        logic [7:0]       value;
        logic [OFF_W-1:0] offset;
        logic             last;
        t_status          status;
    } t_cmd;

endpackage

// ----- rtl/core/lz77_token_stream_decoder_top.sv -----
// top level of the lz77 token stream decoder
//
// input channel: i_valid / o_ready with i_item (token_byte, stream_end), one
// compressed byte per transfer. output channel: o_valid / i_ready with
// o_chunk (chunk_data, chunk_count, last_of_stream, decode_status), up to
// eight decoded bytes per transfer, first byte in bits 7:0.
// the parser takes one byte per cycle while its four-entry command queue has
// room; a flag, offset or bad match byte makes a command only at stream end.
// the copy engine takes a literal through its idle and put states and a match
// through its idle state, then a read and a put state per byte: each copied
// byte is one read then one write of the history ram (one write port, one
// read port), so the input stalls once the queue fills behind a long match.
// with an idle engine a literal's chunk passes from the queue through the
// idle and put states to the output register on o_valid, and a match's last
// chunk after its length byte through a read and a put state per byte.
// reset (synchronous, active low) empties the queue and clears the parser;
// the history ram is not cleared and needs no clearing pass.
// if the receiver holds i_ready low the output register holds its chunk, the
// copy engine waits at its next chunk to emit and the queue then backs up.
module lz77_token_stream_decoder_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  ltsd_pkg::t_in_item   i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output ltsd_pkg::t_out_chunk o_chunk
);
    import ltsd_pkg::*;

    logic push, pop, full, empty;
    t_cmd cmd_in, cmd_head;

    ltsd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (cmd_in)
    );

    ltsd_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cmd_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (cmd_head)
    );

    ltsd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (cmd_head),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_chunk (o_chunk)
    );

endmodule

// ----- rtl/core/ltsd_ram.sv -----
// generic single write port ram with registered read
module ltsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/ltsd_front.sv -----
// token parser: accepts compressed bytes and issues copy commands
module ltsd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ltsd_pkg::t_in_item i_item,
    input  logic              i_full,
    output logic              o_push,
    output ltsd_pkg::t_cmd    o_cmd
);
    import ltsd_pkg::*;

    typedef enum logic [2:0] {
        PH_FLAG,
        PH_LIT,
        PH_OFFHI,
        PH_OFFLO,
        PH_LEN
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [OFF_W-1:0]  r_off, n_off;
    logic [PROD_W-1:0] r_pc, n_pc;
    logic              r_halted, n_halted;
    logic              accept;
    logic [LEN_W-1:0]  len;
    logic [PROD_W-1:0] pc_sum;
    logic [7:0]        b;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign b       = i_item.token_byte;
    assign len     = LEN_W'(b) + MIN_MATCH;

    // parse one byte
    always_comb begin
        n_phase  = r_phase;
        n_off    = r_off;
        n_pc     = r_pc;
        n_halted = r_halted;
        o_cmd    = '{kind: CMD_NONE, value: b, offset: r_off, last: 1'b0, status: ST_OK};
        pc_sum   = r_pc + PROD_W'(len);
        if (!r_halted) begin
            unique case (r_phase)
                PH_FLAG: begin
                    n_phase = b[FLAG_BIT] ? PH_OFFHI : PH_LIT;
                end
                PH_LIT: begin
                    o_cmd.kind = CMD_LIT;
                    n_phase    = PH_FLAG;
                    if (r_pc < PROD_W'(HISTORY_BYTES)) begin
                        n_pc = r_pc + PROD_W'(1);
                    end
                end
                PH_OFFHI: begin
                    n_off   = {4'(b & OFFSET_HI_MASK), 8'h00};
                    n_phase = PH_OFFLO;
                end
                PH_OFFLO: begin
                    n_off   = {r_off[OFF_W-1:8], b};
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    n_phase = PH_FLAG;
                    if (r_off == '0 || PROD_W'(r_off) > r_pc) begin
                        n_halted = 1'b1;
                    end else begin
                        o_cmd.kind = CMD_MATCH;
                        n_pc = (pc_sum > PROD_W'(HISTORY_BYTES)) ?
                               PROD_W'(HISTORY_BYTES) : pc_sum;
                    end
                end
                default: begin
                    n_phase = PH_FLAG;
                end
            endcase
        end
        // end of stream closes the result and clears the parser
        if (i_item.stream_end) begin
            o_cmd.last = 1'b1;
            if (n_halted) begin
                o_cmd.status = ST_BAD_OFFSET;
            end else if (n_phase != PH_FLAG) begin
                o_cmd.status = ST_TRUNC;
            end
            n_phase  = PH_FLAG;
            n_off    = '0;
            n_pc     = '0;
            n_halted = 1'b0;
        end
        o_push = accept && (o_cmd.kind != CMD_NONE || i_item.stream_end);
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_FLAG;
            r_off    <= '0;
            r_pc     <= '0;
            r_halted <= 1'b0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_off    <= n_off;
            r_pc     <= n_pc;
            r_halted <= n_halted;
        end
    end

endmodule

// ----- rtl/core/ltsd_cmd_fifo.sv -----
// short command queue between parser and copy engine
module ltsd_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ltsd_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output ltsd_pkg::t_cmd o_head
);
    import ltsd_pkg::*;

    t_cmd               r_data [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr, r_rd;
    logic [FIFO_AW:0]   r_count;

    assign o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_data[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + FIFO_AW'(1);
            end
            r_count <= r_count + (FIFO_AW+1)'(i_push) - (FIFO_AW+1)'(i_pop);
        end
    end

endmodule

// ----- rtl/core/ltsd_back.sv -----
// copy engine: writes history, copies matches and packs output chunks
module ltsd_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  ltsd_pkg::t_cmd        i_head,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output ltsd_pkg::t_out_chunk  o_chunk
);
    import ltsd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_PUT
    } t_state;

    t_state             r_state, n_state;
    logic [HIST_AW-1:0] r_wp, n_wp;
    logic [LEN_W-1:0]   r_rem, n_rem;
    logic [OFF_W-1:0]   r_off, n_off;
    logic               r_last, n_last;
    t_status            r_status, n_status;
    logic               r_is_lit, n_is_lit;
    logic [7:0]         r_lit, n_lit;
    logic [DATA_W-1:0]  r_acc, n_acc;
    logic [IDX_W-1:0]   r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;
    t_out_chunk         r_out, n_out;

    logic               ram_we, ram_re;
    logic [HIST_AW-1:0] ram_raddr;
    logic [7:0]         ram_rdata, put_byte;
    logic               out_free, put_done, put_emit;
    logic [DATA_W-1:0]  acc_new;

    ltsd_ram #(.WIDTH(8), .DEPTH(HISTORY_BYTES)) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (put_byte),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ram_raddr = r_wp - HIST_AW'(r_off);
    assign put_byte  = r_is_lit ? r_lit : ram_rdata;
    assign out_free  = !r_out_valid || i_ready;
    assign put_done  = (r_rem == LEN_W'(1));
    assign put_emit  = put_done || (r_cnt == IDX_W'(CHUNK_BYTES - 1));

    // next state
    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_rem       = r_rem;
        n_off       = r_off;
        n_last      = r_last;
        n_status    = r_status;
        n_is_lit    = r_is_lit;
        n_lit       = r_lit;
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        o_pop       = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        acc_new     = r_acc;
        acc_new[{r_cnt, 3'b000} +: 8] = put_byte;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_last   = i_head.last;
                    n_status = i_head.status;
                    n_off    = i_head.offset;
                    n_lit    = i_head.value;
                    unique case (i_head.kind)
                        CMD_LIT: begin
                            o_pop    = 1'b1;
                            n_is_lit = 1'b1;
                            n_rem    = LEN_W'(1);
                            n_state  = S_PUT;
                        end
                        CMD_MATCH: begin
                            o_pop    = 1'b1;
                            n_is_lit = 1'b0;
                            n_rem    = LEN_W'(i_head.value) + MIN_MATCH;
                            n_state  = S_RD;
                        end
                        default: begin
                            // stream end with no bytes: empty closing chunk
                            if (out_free) begin
                                o_pop       = 1'b1;
                                n_out_valid = 1'b1;
                                n_out       = '{chunk_data: '0, chunk_count: '0,
                                                last_of_stream: i_head.last,
                                                decode_status: i_head.status};
                            end
                        end
                    endcase
                end
            end
            S_RD: begin
                ram_re  = 1'b1;
                n_state = S_PUT;
            end
            S_PUT: begin
                if (!put_emit || out_free) begin
                    ram_we = 1'b1;
                    n_wp   = r_wp + HIST_AW'(1);
                    n_rem  = r_rem - LEN_W'(1);
                    if (put_emit) begin
                        n_out_valid = 1'b1;
                        n_out.chunk_data     = acc_new;
                        n_out.chunk_count    = CNT_W'(r_cnt) + CNT_W'(1);
                        n_out.last_of_stream = put_done && r_last;
                        n_out.decode_status  = (put_done && r_last) ? r_status : ST_OK;
                        n_acc = '0;
                        n_cnt = '0;
                    end else begin
                        n_acc = acc_new;
                        n_cnt = r_cnt + IDX_W'(1);
                    end
                    n_state = put_done ? S_IDLE : S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_rem       <= '0;
            r_acc       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_rem       <= n_rem;
            r_acc       <= n_acc;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_off    <= n_off;
        r_last   <= n_last;
        r_status <= n_status;
        r_is_lit <= n_is_lit;
        r_lit    <= n_lit;
        r_out    <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_chunk = r_out;

`ifndef SYNTHESIS
    a_rd_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RD |-> r_rem != '0)
        else $error("copy read issued with no bytes left");
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.chunk_count == '0) |-> r_out.last_of_stream)
        else $error("empty chunk that does not close a stream");
    a_status_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last_of_stream) |-> r_out.decode_status == ST_OK)
        else $error("status reported before the end of the stream");
`endif

endmodule

// ----- test/tb_lz77_token_stream_decoder_top.sv -----
// testbench of the lz77 token stream decoder: token streams in, chunks checked
module tb_lz77_token_stream_decoder_top;
    import ltsd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        PH_FLAG  = 3'd0,
        PH_LIT   = 3'd1,
        PH_OFFHI = 3'd2,
        PH_OFFLO = 3'd3,
        PH_LEN   = 3'd4
    } t_phase;

    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int DRAIN_CYCLES = 600;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    t_in_item   i_item;
    logic       o_valid;
    logic       i_ready;
    t_out_chunk o_chunk;

    lz77_token_stream_decoder_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_chunk (o_chunk)
    );

    // predictor state of one stream
    logic [7:0]         ring [HISTORY_BYTES];
    logic [HIST_AW-1:0] wr_ptr;
    int                 produced;
    t_phase             phase;
    logic [OFF_W-1:0]   off_hold;
    bit                 halted;
    t_status            err_hold;

    t_out_chunk chunk_queue [$];
    int         mismatch_count;
    int         cycle_count;
    int         send_idle_pct;
    int         recv_idle_pct;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    task automatic clear_stream();
        wr_ptr   = '0;
        produced = 0;
        phase    = PH_FLAG;
        off_hold = '0;
        halted   = 1'b0;
        err_hold = ST_OK;
    endtask

    task automatic store_byte(input logic [7:0] b);
        ring[wr_ptr] = b;
        wr_ptr++;
        if (produced < HISTORY_BYTES) produced++;
    endtask

    task automatic push_chunk(input logic [DATA_W-1:0] data, input int cnt,
                              input logic last, input t_status st);
        t_out_chunk c;
        c.chunk_data     = data;
        c.chunk_count    = CNT_W'(cnt);
        c.last_of_stream = last;
        c.decode_status  = st;
        chunk_queue.insert(chunk_queue.size(), c);
    endtask

    // expected chunks for one accepted byte
    task automatic decode_byte(input t_in_item it);
        logic [DATA_W-1:0] acc;
        int                cnt;
        int                made;
        int                len;
        t_status           st;
        logic [7:0]        v;
        acc  = '0;
        cnt  = 0;
        made = 0;
        if (!halted) begin
            case (phase)
                PH_LIT: begin
                    store_byte(it.token_byte);
                    acc   = DATA_W'(it.token_byte);
                    cnt   = 1;
                    phase = PH_FLAG;
                end
                PH_OFFHI: begin
                    off_hold = {it.token_byte[3:0], 8'h00};
                    phase    = PH_OFFLO;
                end
                PH_OFFLO: begin
                    off_hold[7:0] = it.token_byte;
                    phase         = PH_LEN;
                end
                PH_LEN: begin
                    len   = int'(it.token_byte) + 3;
                    phase = PH_FLAG;
                    if (off_hold == 0 || int'(off_hold) > produced) begin
                        halted   = 1'b1;
                        err_hold = ST_BAD_OFFSET;
                    end else begin
                        for (int k = 0; k < len; k++) begin
                            v = ring[wr_ptr - off_hold];
                            store_byte(v);
                            acc[8*cnt +: 8] = v;
                            cnt++;
                            if (cnt >= CHUNK_BYTES) begin
                                push_chunk(acc, cnt, 1'b0, ST_OK);
                                made++;
                                acc = '0;
                                cnt = 0;
                            end
                        end
                    end
                end
                default: phase = it.token_byte[FLAG_BIT] ? PH_OFFHI : PH_LIT;
            endcase
        end
        if (!it.stream_end) begin
            if (cnt > 0) push_chunk(acc, cnt, 1'b0, ST_OK);
        end else begin
            if (halted) st = err_hold;
            else if (phase != PH_FLAG) st = ST_TRUNC;
            else st = ST_OK;
            if (cnt > 0 || made == 0) begin
                push_chunk(acc, cnt, 1'b1, st);
            end else begin
                chunk_queue[$].last_of_stream = 1'b1;
                chunk_queue[$].decode_status  = st;
            end
            clear_stream();
        end
    endtask

    // send one byte, predicting at acceptance; valid drops only for idle gaps
    task automatic send_byte(input logic [7:0] b, input logic e);
        t_in_item it;
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        it.token_byte = b;
        it.stream_end = e;
        i_item  <= it;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        decode_byte(it);
    endtask

    // receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result check
    always @(posedge i_clk) begin
        t_out_chunk exp_c;
        if (i_rst_n && o_valid && i_ready) begin
            if (chunk_queue.size() == 0) begin
                report_mismatch("chunk with none expected");
            end else begin
                exp_c = chunk_queue.pop_front();
                if (o_chunk.chunk_data !== exp_c.chunk_data)
                    report_mismatch($sformatf("data %h exp %h",
                        o_chunk.chunk_data, exp_c.chunk_data));
                if (o_chunk.chunk_count !== exp_c.chunk_count)
                    report_mismatch($sformatf("count %0d exp %0d",
                        o_chunk.chunk_count, exp_c.chunk_count));
                if (o_chunk.last_of_stream !== exp_c.last_of_stream)
                    report_mismatch($sformatf("last %b exp %b",
                        o_chunk.last_of_stream, exp_c.last_of_stream));
                if (o_chunk.decode_status !== exp_c.decode_status)
                    report_mismatch($sformatf("status %0d exp %0d",
                        o_chunk.decode_status, exp_c.decode_status));
            end
        end
    end

    task automatic send_literal(input logic [7:0] flag, input logic [7:0] b,
                                input logic e);
        send_byte(flag & 8'h7F, 1'b0);
        send_byte(b, e);
    endtask

    task automatic send_match(input logic [7:0] flag, input logic [11:0] off,
                              input logic [7:0] lm3, input logic e);
        send_byte(flag | 8'h80, 1'b0);
        send_byte({4'($urandom_range(15)), off[11:8]}, 1'b0);
        send_byte(off[7:0], 1'b0);
        send_byte(lm3, e);
    endtask

    // extremes, overlap, bad offsets, truncation
    task automatic test_directed();
        send_literal(8'h00, 8'h00, 1'b0);
        send_literal(8'h7F, 8'hFF, 1'b0);
        send_match(8'h80, 12'd1, 8'd0, 1'b0);
        send_match(8'hFF, 12'd2, 8'd255, 1'b1);
        send_literal(8'h55, 8'hA5, 1'b0);
        send_match(8'h80, 12'd0, 8'd5, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b1);
        send_literal(8'h01, 8'h5A, 1'b0);
        send_match(8'h80, 12'd2, 8'd1, 1'b1);
        send_byte(8'h80, 1'b1);
        send_literal(8'h00, 8'h11, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    // random streams: mostly well-formed tokens, some noise
    task automatic test_random(input int n_bytes);
        int sent;
        int toks;
        logic e;
        int off;
        sent = 0;
        while (sent < n_bytes) begin
            toks = $urandom_range(1, 12);
            for (int t = 0; t < toks; t++) begin
                e = (t == toks - 1);
                if ($urandom_range(19) == 0) begin
                    send_byte(8'($urandom_range(255)), e);
                    sent += 1;
                end else if (produced == 0 || $urandom_range(2) == 0) begin
                    send_literal(8'($urandom_range(255)), 8'($urandom_range(255)), e);
                    sent += 2;
                end else begin
                    if ($urandom_range(15) == 0) off = $urandom_range(4095);
                    else off = $urandom_range(1, produced);
                    send_match(8'($urandom_range(255)), 12'(off),
                        ($urandom_range(7) == 0) ? 8'($urandom_range(255))
                                                 : 8'($urandom_range(12)), e);
                    sent += 4;
                end
            end
        end
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        while (chunk_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_item         = '0;
        i_ready        = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        send_idle_pct  = 8;
        recv_idle_pct  = 53;
        clear_stream();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(110);
        send_idle_pct = 53;
        recv_idle_pct = 8;
        test_random(110);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(110);
        wait_drain();
        if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
